@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the date unit RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ hw/rtl/gdc_pkg.sv @@
// Shared types, codes and calendar tables for the date unit
`default_nettype none
package gdc_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int OFF_W   = 23;
   localparam int DN_W    = 22;
   localparam int DOY_W   = 9;
   localparam int WD_W    = 3;

   localparam int unsigned YEAR_MAX   = 9999;
   localparam int unsigned DAYS_TOTAL = 3652059;
   localparam int unsigned D400       = 146097;
   localparam int unsigned D100       = 36524;
   localparam int unsigned D4         = 1461;
   localparam int unsigned D1         = 365;

   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_DIFF = 2'd1;

   localparam logic [1:0] UNIT_DAYS   = 2'd0;
   localparam logic [1:0] UNIT_MONTHS = 2'd1;
   localparam logic [1:0] UNIT_YEARS  = 2'd2;
   localparam logic [1:0] UNIT_ZERO   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic             ok;
      logic [DAY_W-1:0] mlen;
      logic [DOY_W-1:0] doy;
      logic [DN_W-1:0]  dn;
   } d2n_out_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [DOY_W-1:0]   doy;
      logic [DAY_W-1:0]   mlen;
      logic [WD_W-1:0]    wd;
   } n2d_out_type;

   // days before the first of month m; months outside 1..12 give 0
   function automatic logic [DOY_W-1:0] month_start(logic [MONTH_W-1:0] m, logic leap);
      logic [DOY_W-1:0] base;
      unique case (m)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + 9'((leap && m > 4'd2 && m <= 4'd12) ? 1 : 0);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/gregorian_date_calculator.sv @@
// Gregorian date unit top level: shift, difference and description of dates
`default_nettype none
// Proleptic Gregorian date unit for years 1 to 9999. Each request gives exactly one
// response, in order: opcode 0 shifts date A by day_offset, opcode 1 gives date B minus
// date A in days, months, whole 365-day years or zero, and opcodes 2 and 3 describe
// date A. Every good response carries the date with its weekday (0 is Sunday), day of
// year and month length; a bad input date gives status 1, a shift leaving the calendar
// gives status 2, and then all other fields are zero. The datapath is a 14-stage
// pipeline with every division done by constant reciprocal multiplies or shifts, so one
// request is taken per clock unless a response waits at the output. The whole
// pipeline holds while a response waits at the output, so req_ready follows
// rsp_ready combinationally whenever the output register is full.
`include "assert_macros.svh"
module gregorian_date_calculator import gdc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_opcode,
   input  wire logic [YEAR_W-1:0]        req_year_a,
   input  wire logic [MONTH_W-1:0]       req_month_a,
   input  wire logic [DAY_W-1:0]         req_day_a,
   input  wire logic [YEAR_W-1:0]        req_year_b,
   input  wire logic [MONTH_W-1:0]       req_month_b,
   input  wire logic [DAY_W-1:0]         req_day_b,
   input  wire logic signed [OFF_W-1:0]  req_day_offset,
   input  wire logic [1:0]               req_diff_unit,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [YEAR_W-1:0]             rsp_res_year,
   output logic [MONTH_W-1:0]            rsp_res_month,
   output logic [DAY_W-1:0]              rsp_res_day,
   output logic [WD_W-1:0]               rsp_weekday,
   output logic [DOY_W-1:0]              rsp_year_day,
   output logic [DAY_W-1:0]              rsp_month_length,
   output logic signed [OFF_W-1:0]       rsp_difference
);

   localparam int LAT    = 14;
   localparam int D2N_LAT = 3;
   localparam int TAIL   = 9;
   localparam longint unsigned K365 = ((64'd1 << 31) + 64'(D1) - 64'd1) / 64'(D1);

   typedef struct packed {
      logic [1:0]              op;
      logic [1:0]              unit;
      logic [YEAR_W-1:0]       ya;
      logic [YEAR_W-1:0]       yb;
      logic [MONTH_W-1:0]      ma;
      logic [MONTH_W-1:0]      mb;
      logic [DAY_W-1:0]        da;
      logic [DAY_W-1:0]        db;
      logic signed [OFF_W-1:0] off;
   } side_type;

   typedef struct packed {
      logic [1:0]              status;
      logic                    is_diff;
      logic [1:0]              unit;
      logic signed [OFF_W-1:0] days;
      logic [DN_W-1:0]         abs_days;
      logic                    neg;
      logic signed [17:0]      mdiff;
   } mid_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [OFF_W-1:0] diff;
   } tail_type;

   // One enable for every stage: advance whenever the output register can move on
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Valid bits travel alongside the data, one per register stage
   logic [LAT-1:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Stages 1 to 3: both dates to day numbers; the raw request fields ride alongside
   d2n_out_type a_res, b_res;

   gdc_d2n u_d2n_a (
      .clock  (clock),
      .en     (en),
      .year   (req_year_a),
      .month  (req_month_a),
      .day    (req_day_a),
      .result (a_res)
   );

   gdc_d2n u_d2n_b (
      .clock  (clock),
      .en     (en),
      .year   (req_year_b),
      .month  (req_month_b),
      .day    (req_day_b),
      .result (b_res)
   );

   side_type side_ff [D2N_LAT];
   side_type side_in;

   always_comb begin
      side_in.op   = req_opcode;
      side_in.unit = req_diff_unit;
      side_in.ya   = req_year_a;
      side_in.yb   = req_year_b;
      side_in.ma   = req_month_a;
      side_in.mb   = req_month_b;
      side_in.da   = req_day_a;
      side_in.db   = req_day_b;
      side_in.off  = req_day_offset;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < D2N_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Stage 4: shift, range check, raw day and month differences
   side_type           sd;
   logic               is_add, is_diff, bad, oor, inc;
   logic signed [24:0] shifted;
   logic signed [22:0] days;
   logic signed [17:0] ya_s, yb_s, ma_s, mb_s, mdiff;
   mid_type            mid_ff, mid_in;
   logic [DN_W-1:0]    dn_ff, dn_in;

   assign sd      = side_ff[D2N_LAT-1];
   assign is_add  = (sd.op == OP_ADD);
   assign is_diff = (sd.op == OP_DIFF);
   assign bad     = !a_res.ok || (is_diff && !b_res.ok);
   assign shifted = $signed({3'b000, a_res.dn}) + $signed({{2{sd.off[OFF_W-1]}}, sd.off});
   assign oor     = (shifted < 25'sd0) || (shifted > $signed(25'(DAYS_TOTAL - 1)));
   assign days    = $signed({1'b0, b_res.dn}) - $signed({1'b0, a_res.dn});
   assign ya_s    = 18'(sd.ya);
   assign yb_s    = 18'(sd.yb);
   assign ma_s    = 18'(sd.ma);
   assign mb_s    = 18'(sd.mb);
   // count the current month too unless day B falls short or A ends its month
   assign inc     = (sd.db >= sd.da) && (sd.da != a_res.mlen);
   assign mdiff   = (mb_s - ma_s) + 18'sd12 * (yb_s - ya_s) + 18'(inc);

   always_comb begin
      priority if (bad) begin
         mid_in.status = ST_BAD;
      end else if (is_add && oor) begin
         mid_in.status = ST_RANGE;
      end else begin
         mid_in.status = ST_OK;
      end
      mid_in.is_diff  = is_diff;
      mid_in.unit     = sd.unit;
      mid_in.days     = days;
      mid_in.neg      = days[OFF_W-1];
      mid_in.abs_days = days[OFF_W-1] ? DN_W'(-days) : days[DN_W-1:0];
      mid_in.mdiff    = mdiff;
      dn_in           = is_add ? shifted[DN_W-1:0] : a_res.dn;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mid_ff <= mid_in;
         dn_ff  <= dn_in;
      end
   end

   // Stages 5 to 13: day number back to a calendar date
   n2d_out_type date_res;

   gdc_n2d u_n2d (
      .clock  (clock),
      .en     (en),
      .dn     (dn_ff),
      .result (date_res)
   );

   // Stage 5: choose the difference in its unit; years truncate toward zero
   logic [45:0]             p365;
   logic [13:0]             years;
   logic signed [OFF_W-1:0] diff_sel;
   tail_type                tail_in;
   tail_type                tail_ff [TAIL];

   assign p365  = 46'(mid_ff.abs_days) * 46'(K365);
   assign years = p365[44:31];

   always_comb begin
      diff_sel = '0;
      if (mid_ff.is_diff && (mid_ff.days != '0) && (mid_ff.status == ST_OK)) begin
         unique case (mid_ff.unit)
            UNIT_DAYS:   diff_sel = mid_ff.days;
            UNIT_MONTHS: diff_sel = OFF_W'(mid_ff.mdiff);
            UNIT_YEARS:  diff_sel = mid_ff.neg ? -$signed(OFF_W'(years))
                                               : $signed(OFF_W'(years));
            UNIT_ZERO:   diff_sel = '0;
         endcase
      end
      tail_in.status = mid_ff.status;
      tail_in.diff   = diff_sel;
   end

   // Hold status and difference until the date conversion catches up
   always_ff @(posedge clock) begin
      if (en) begin
         tail_ff[0] <= tail_in;
         for (int i = 1; i < TAIL; i++) begin
            tail_ff[i] <= tail_ff[i-1];
         end
      end
   end

   // Stage 14: output register; any bad status drops every other field to zero
   tail_type                last;
   logic                    good;
   logic [1:0]              status_in;
   logic [YEAR_W-1:0]       year_ff, year_in;
   logic [MONTH_W-1:0]      month_ff, month_in;
   logic [DAY_W-1:0]        day_ff, day_in;
   logic [WD_W-1:0]         wd_ff, wd_in;
   logic [DOY_W-1:0]        doy_ff, doy_in;
   logic [DAY_W-1:0]        mlen_ff, mlen_in;
   logic signed [OFF_W-1:0] diff_ff, diff_in;
   logic [1:0]              status_ff;

   assign last      = tail_ff[TAIL-1];
   assign good      = (last.status == ST_OK);
   assign status_in = last.status;
   assign year_in   = good ? date_res.year  : '0;
   assign month_in  = good ? date_res.month : '0;
   assign day_in    = good ? date_res.day   : '0;
   assign wd_in     = good ? date_res.wd    : '0;
   assign doy_in    = good ? date_res.doy   : '0;
   assign mlen_in   = good ? date_res.mlen  : '0;
   assign diff_in   = good ? last.diff      : '0;

   always_ff @(posedge clock) begin
      if (en) begin
         status_ff <= status_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         wd_ff     <= wd_in;
         doy_ff    <= doy_in;
         mlen_ff   <= mlen_in;
         diff_ff   <= diff_in;
      end
   end

   assign rsp_valid        = vld_ff[LAT-1];
   assign rsp_status       = status_ff;
   assign rsp_res_year     = year_ff;
   assign rsp_res_month    = month_ff;
   assign rsp_res_day      = day_ff;
   assign rsp_weekday      = wd_ff;
   assign rsp_year_day     = doy_ff;
   assign rsp_month_length = mlen_ff;
   assign rsp_difference   = diff_ff;

   `ASSERT_CLK(a_bad_clears, clock, reset, (rsp_valid && rsp_status != ST_OK) |-> (rsp_res_year == '0 && rsp_res_month == '0 && rsp_difference == '0), "failed response carries data")
   `ASSERT_CLK(a_good_date, clock, reset, (rsp_valid && rsp_status == ST_OK) |-> (rsp_res_month >= 4'd1 && rsp_res_month <= 4'd12 && rsp_res_day >= 5'd1 && rsp_res_day <= rsp_month_length), "response date malformed")
   `ASSERT_CLK(a_good_fields, clock, reset, (rsp_valid && rsp_status == ST_OK) |-> (rsp_weekday <= 3'd6 && rsp_year_day <= 9'd365 && rsp_month_length >= 5'd28), "weekday or day of year out of range")
   `ASSERT_NEVER(a_bad_status, clock, reset, rsp_valid && rsp_status != ST_OK && rsp_status != ST_BAD && rsp_status != ST_RANGE, "unknown status code")

endmodule
`default_nettype wire

@@ hw/rtl/gdc_d2n.sv @@
// Date check and date-to-day-number conversion, three register stages
`default_nettype none
module gdc_d2n import gdc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [YEAR_W-1:0]  year,
   input  wire logic [MONTH_W-1:0] month,
   input  wire logic [DAY_W-1:0]   day,
   output d2n_out_type             result
);

   localparam logic [12:0] HUND_RECIP = 13'(((1 << 19) + 99) / 100);

   // stage 1: range check and year / 100
   logic [YEAR_W-1:0]  y1_ff;
   logic [MONTH_W-1:0] m1_ff;
   logic [DAY_W-1:0]   d1_ff;
   logic [7:0]         qy1_ff, qy1_in;
   logic               rng1_ff, rng1_in;
   logic [26:0]        qy_prod;

   assign qy_prod = 27'(year) * 27'(HUND_RECIP);
   assign qy1_in  = qy_prod[26:19];
   assign rng1_in = (year >= 14'd1) && (year <= 14'(YEAR_MAX)) && (month >= 4'd1)
                    && (month <= 4'd12) && (day >= 5'd1);

   always_ff @(posedge clock) begin
      if (en) begin
         y1_ff   <= year;
         m1_ff   <= month;
         d1_ff   <= day;
         qy1_ff  <= qy1_in;
         rng1_ff <= rng1_in;
      end
   end

   // stage 2: leap year, month length, day of year
   logic [14:0]        c100;
   logic               ymod0;
   logic               leap2;
   logic [DAY_W-1:0]   mlen2_ff, mlen2_in;
   logic               ok2_ff, ok2_in;
   logic [DOY_W-1:0]   doy2_ff, doy2_in;
   logic [YEAR_W-1:0]  p2_ff, p2_in;
   logic [7:0]         q2_ff, q2_in;

   assign c100     = 15'(qy1_ff) * 15'd100;
   assign ymod0    = ({1'b0, y1_ff} == c100);
   assign leap2    = (y1_ff[1:0] == 2'd0) && (!ymod0 || (qy1_ff[1:0] == 2'd0));
   assign mlen2_in = month_len(m1_ff, leap2);
   assign ok2_in   = rng1_ff && (d1_ff <= mlen2_in);
   assign doy2_in  = month_start(m1_ff, leap2) + 9'(d1_ff) - 9'd1;
   assign p2_in    = y1_ff - 14'd1;
   assign q2_in    = qy1_ff - 8'(ymod0);

   always_ff @(posedge clock) begin
      if (en) begin
         mlen2_ff <= mlen2_in;
         ok2_ff   <= ok2_in;
         doy2_ff  <= doy2_in;
         p2_ff    <= p2_in;
         q2_ff    <= q2_in;
      end
   end

   // stage 3: day number, day 0 is 0001-01-01
   logic [22:0]  dn3;
   d2n_out_type  res_ff, res_in;

   assign dn3 = 23'(p2_ff) * 23'd365 + 23'(p2_ff >> 2) - 23'(q2_ff) + 23'(q2_ff >> 2)
                + 23'(doy2_ff);

   always_comb begin
      res_in.ok   = ok2_ff;
      res_in.mlen = mlen2_ff;
      res_in.doy  = doy2_ff;
      res_in.dn   = dn3[DN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule
`default_nettype wire

@@ hw/rtl/gdc_n2d.sv @@
// Day-number-to-date conversion and weekday, nine register stages
`default_nettype none
module gdc_n2d import gdc_pkg::*; (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire logic [DN_W-1:0] dn,
   output n2d_out_type          result
);

   localparam longint unsigned K400 = ((64'd1 << 40) + 64'(D400) - 64'd1) / 64'(D400);
   localparam longint unsigned K100 = ((64'd1 << 34) + 64'(D100) - 64'd1) / 64'(D100);
   localparam longint unsigned K4   = ((64'd1 << 27) + 64'(D4) - 64'd1) / 64'(D4);
   localparam longint unsigned K1   = ((64'd1 << 20) + 64'(D1) - 64'd1) / 64'(D1);
   localparam longint unsigned K7   = ((64'd1 << 25) + 64'd6) / 64'd7;

   // stage 1: 400-year cycles and weekday quotient
   logic [44:0] p400;
   logic [45:0] p7;
   logic [22:0] x7;
   logic [DN_W-1:0] s1_dn_ff;
   logic [4:0]  s1_q400_ff, s1_q400_in;
   logic [22:0] s1_x7_ff;
   logic [19:0] s1_wq_ff, s1_wq_in;

   assign x7         = 23'(dn) + 23'd1;
   assign p400       = 45'(dn) * 45'(K400);
   assign p7         = 46'(x7) * 46'(K7);
   assign s1_q400_in = p400[44:40];
   assign s1_wq_in   = p7[44:25];

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dn_ff   <= dn;
         s1_q400_ff <= s1_q400_in;
         s1_x7_ff   <= x7;
         s1_wq_ff   <= s1_wq_in;
      end
   end

   // stage 2: remainders
   logic [21:0] r400_full;
   logic [22:0] wd_full;
   logic [17:0] s2_r400_ff;
   logic [4:0]  s2_q400_ff;
   logic [WD_W-1:0] s2_wd_ff;

   assign r400_full = s1_dn_ff - 22'(s1_q400_ff) * 22'(D400);
   assign wd_full   = s1_x7_ff - 23'(s1_wq_ff) * 23'd7;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_r400_ff <= r400_full[17:0];
         s2_q400_ff <= s1_q400_ff;
         s2_wd_ff   <= wd_full[WD_W-1:0];
      end
   end

   // stage 3: centuries, last day of a 400-year cycle stays in century 3
   logic [36:0] p100;
   logic [2:0]  q100_raw;
   logic [17:0] s3_r400_ff;
   logic [4:0]  s3_q400_ff;
   logic [1:0]  s3_q100_ff, s3_q100_in;
   logic [WD_W-1:0] s3_wd_ff;

   assign p100       = 37'(s2_r400_ff) * 37'(K100);
   assign q100_raw   = p100[36:34];
   assign s3_q100_in = (q100_raw > 3'd3) ? 2'd3 : q100_raw[1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         s3_r400_ff <= s2_r400_ff;
         s3_q400_ff <= s2_q400_ff;
         s3_q100_ff <= s3_q100_in;
         s3_wd_ff   <= s2_wd_ff;
      end
   end

   // stage 4
   logic [17:0] r100_full;
   logic [15:0] s4_r100_ff;
   logic [4:0]  s4_q400_ff;
   logic [1:0]  s4_q100_ff;
   logic [WD_W-1:0] s4_wd_ff;

   assign r100_full = s3_r400_ff - 18'(s3_q100_ff) * 18'(D100);

   always_ff @(posedge clock) begin
      if (en) begin
         s4_r100_ff <= r100_full[15:0];
         s4_q400_ff <= s3_q400_ff;
         s4_q100_ff <= s3_q100_ff;
         s4_wd_ff   <= s3_wd_ff;
      end
   end

   // stage 5: 4-year cycles
   logic [32:0] p4;
   logic [15:0] s5_r100_ff;
   logic [4:0]  s5_q400_ff, s5_q4_ff;
   logic [1:0]  s5_q100_ff;
   logic [WD_W-1:0] s5_wd_ff;

   assign p4 = 33'(s4_r100_ff) * 33'(K4);

   always_ff @(posedge clock) begin
      if (en) begin
         s5_r100_ff <= s4_r100_ff;
         s5_q400_ff <= s4_q400_ff;
         s5_q100_ff <= s4_q100_ff;
         s5_q4_ff   <= p4[31:27];
         s5_wd_ff   <= s4_wd_ff;
      end
   end

   // stage 6
   logic [15:0] r4_full;
   logic [10:0] s6_r4_ff;
   logic [4:0]  s6_q400_ff, s6_q4_ff;
   logic [1:0]  s6_q100_ff;
   logic [WD_W-1:0] s6_wd_ff;

   assign r4_full = s5_r100_ff - 16'(s5_q4_ff) * 16'(D4);

   always_ff @(posedge clock) begin
      if (en) begin
         s6_r4_ff   <= r4_full[10:0];
         s6_q400_ff <= s5_q400_ff;
         s6_q100_ff <= s5_q100_ff;
         s6_q4_ff   <= s5_q4_ff;
         s6_wd_ff   <= s5_wd_ff;
      end
   end

   // stage 7: single years, last day of a 4-year cycle stays in year 3
   logic [22:0] p1;
   logic [2:0]  q1_raw;
   logic [10:0] s7_r4_ff;
   logic [4:0]  s7_q400_ff, s7_q4_ff;
   logic [1:0]  s7_q100_ff, s7_q1_ff, s7_q1_in;
   logic [WD_W-1:0] s7_wd_ff;

   assign p1       = 23'(s6_r4_ff) * 23'(K1);
   assign q1_raw   = p1[22:20];
   assign s7_q1_in = (q1_raw > 3'd3) ? 2'd3 : q1_raw[1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         s7_r4_ff   <= s6_r4_ff;
         s7_q400_ff <= s6_q400_ff;
         s7_q100_ff <= s6_q100_ff;
         s7_q4_ff   <= s6_q4_ff;
         s7_q1_ff   <= s7_q1_in;
         s7_wd_ff   <= s6_wd_ff;
      end
   end

   // stage 8: year and day of year
   logic [10:0] r1_full;
   logic [15:0] year_full;
   logic [DOY_W-1:0]  s8_r1_ff;
   logic [YEAR_W-1:0] s8_year_ff;
   logic              s8_leap_ff, s8_leap_in;
   logic [WD_W-1:0]   s8_wd_ff;

   assign r1_full    = s7_r4_ff - 11'(s7_q1_ff) * 11'(D1);
   assign year_full  = 16'(s7_q400_ff) * 16'd400 + 16'(s7_q100_ff) * 16'd100
                       + 16'(s7_q4_ff) * 16'd4 + 16'(s7_q1_ff) + 16'd1;
   assign s8_leap_in = (s7_q1_ff == 2'd3) && ((s7_q4_ff != 5'd24) || (s7_q100_ff == 2'd3));

   always_ff @(posedge clock) begin
      if (en) begin
         s8_r1_ff   <= r1_full[DOY_W-1:0];
         s8_year_ff <= year_full[YEAR_W-1:0];
         s8_leap_ff <= s8_leap_in;
         s8_wd_ff   <= s7_wd_ff;
      end
   end

   // stage 9: month and day of month
   logic [10:0]        ge;
   logic [MONTH_W-1:0] mon;
   logic [DOY_W-1:0]   dom_full;
   n2d_out_type        res_ff, res_in;

   always_comb begin
      for (int k = 1; k < 12; k++) begin
         ge[k-1] = (s8_r1_ff >= month_start(4'(k + 1), s8_leap_ff));
      end
   end

   assign mon      = 4'd1 + 4'($countones(ge));
   assign dom_full = s8_r1_ff - month_start(mon, s8_leap_ff) + 9'd1;

   always_comb begin
      res_in.year  = s8_year_ff;
      res_in.month = mon;
      res_in.day   = dom_full[DAY_W-1:0];
      res_in.doy   = s8_r1_ff;
      res_in.mlen  = month_len(mon, s8_leap_ff);
      res_in.wd    = s8_wd_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the Gregorian date unit
`timescale 1ns / 1ps

import gdc_pkg::*;

typedef struct packed {
   logic [1:0]              opcode;
   logic [YEAR_W-1:0]       year_a;
   logic [MONTH_W-1:0]      month_a;
   logic [DAY_W-1:0]        day_a;
   logic [YEAR_W-1:0]       year_b;
   logic [MONTH_W-1:0]      month_b;
   logic [DAY_W-1:0]        day_b;
   logic signed [OFF_W-1:0] day_offset;
   logic [1:0]              diff_unit;
} date_req_type;

typedef struct packed {
   logic [1:0]              status;
   logic [YEAR_W-1:0]       year;
   logic [MONTH_W-1:0]      month;
   logic [DAY_W-1:0]        day;
   logic [WD_W-1:0]         weekday;
   logic [DOY_W-1:0]        year_day;
   logic [DAY_W-1:0]        month_length;
   logic signed [OFF_W-1:0] difference;
} date_rsp_type;

localparam logic [1:0] OP_DESCRIBE = 2'd2;
localparam logic [1:0] OP_SPARE    = 2'd3;

function automatic bit leap_year(int y);
   return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
endfunction

function automatic int days_in_month(int y, int m);
   case (m)
      2:             return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
   endcase
endfunction

function automatic int ordinal_day(int y, int m, int d);
   int sum;
   sum = 0;
   for (int k = 1; k < m && k <= 12; k++) sum += days_in_month(y, k);
   return sum + d - 1;
endfunction

function automatic bit valid_date(int y, int m, int d);
   if (y < 1 || y > YEAR_MAX || m < 1 || m > 12 || d < 1) return 0;
   return d <= days_in_month(y, m);
endfunction

// day 0 is 0001-01-01
function automatic longint epoch_day(int y, int m, int d);
   longint p;
   p = y - 1;
   return 365 * p + p / 4 - p / 100 + p / 400 + ordinal_day(y, m, d);
endfunction

function automatic void epoch_to_date(longint dn, output int y, output int m, output int d);
   int r, q400, q100, q4, q1, k;
   r = int'(dn);
   q400 = r / D400;  r = r % D400;
   q100 = r / D100;  if (q100 > 3) q100 = 3;
   r -= q100 * D100;
   q4 = r / D4;      r = r % D4;
   q1 = r / D1;      if (q1 > 3) q1 = 3;
   r -= q1 * D1;
   y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
   k = 1;
   while (k < 12 && r >= days_in_month(y, k)) begin
      r -= days_in_month(y, k);
      k++;
   end
   m = k;
   d = r + 1;
endfunction

class date_scoreboard;
   date_rsp_type pending[$];
   int           mismatches;

   function date_rsp_type compute(date_req_type q);
      date_rsp_type e;
      int ya, ma, da, yb, mb, db, ry, rm, rd;
      longint dna, dn, days, diff;
      e = '0;
      ya = q.year_a;  ma = q.month_a;  da = q.day_a;
      yb = q.year_b;  mb = q.month_b;  db = q.day_b;
      ry = ya;  rm = ma;  rd = da;  diff = 0;
      if (!valid_date(ya, ma, da) || (q.opcode == OP_DIFF && !valid_date(yb, mb, db))) begin
         e.status = ST_BAD;
         return e;
      end
      dna = epoch_day(ya, ma, da);
      if (q.opcode == OP_ADD) begin
         dn = dna + longint'(q.day_offset);
         if (dn < 0 || dn >= DAYS_TOTAL) begin
            e.status = ST_RANGE;
            return e;
         end
         epoch_to_date(dn, ry, rm, rd);
      end else if (q.opcode == OP_DIFF) begin
         days = epoch_day(yb, mb, db) - dna;
         if (days != 0) begin
            case (q.diff_unit)
               UNIT_DAYS:   diff = days;
               UNIT_MONTHS: begin
                  diff = (mb - ma) + 12 * (yb - ya);
                  if (db >= da && da != days_in_month(ya, ma)) diff++;
               end
               UNIT_YEARS:  diff = days / 365;
               default:     diff = 0;
            endcase
         end
      end
      e.status       = ST_OK;
      e.year         = ry;
      e.month        = rm;
      e.day          = rd;
      e.weekday      = (epoch_day(ry, rm, rd) + 1) % 7;
      e.year_day     = ordinal_day(ry, rm, rd);
      e.month_length = days_in_month(ry, rm);
      e.difference   = diff;
      return e;
   endfunction

   function void note(date_req_type q);
      pending.push_back(compute(q));
   endfunction

   function void check(date_rsp_type a);
      date_rsp_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response, status %0d", a.status);
         return;
      end
      e = pending.pop_front();
      if (a != e) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: exp st%0d %0d-%0d-%0d wd%0d yd%0d ml%0d df%0d, ",
                      "got st%0d %0d-%0d-%0d wd%0d yd%0d ml%0d df%0d"},
                     e.status, e.year, e.month, e.day, e.weekday, e.year_day,
                     e.month_length, e.difference, a.status, a.year, a.month,
                     a.day, a.weekday, a.year_day, a.month_length, a.difference);
      end
   endfunction
endclass

module testbench;
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_opcode = '0;
   logic [YEAR_W-1:0]       req_year_a = 14'd1;
   logic [MONTH_W-1:0]      req_month_a = 4'd1;
   logic [DAY_W-1:0]        req_day_a = 5'd1;
   logic [YEAR_W-1:0]       req_year_b = 14'd1;
   logic [MONTH_W-1:0]      req_month_b = 4'd1;
   logic [DAY_W-1:0]        req_day_b = 5'd1;
   logic signed [OFF_W-1:0] req_day_offset = '0;
   logic [1:0]              req_diff_unit = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_status;
   logic [YEAR_W-1:0]       rsp_res_year;
   logic [MONTH_W-1:0]      rsp_res_month;
   logic [DAY_W-1:0]        rsp_res_day;
   logic [WD_W-1:0]         rsp_weekday;
   logic [DOY_W-1:0]        rsp_year_day;
   logic [DAY_W-1:0]        rsp_month_length;
   logic signed [OFF_W-1:0] rsp_difference;

   date_scoreboard calendar_sb = new();
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int unsigned    cycle_count = 0;
   localparam int unsigned CYCLE_LIMIT = 200000;

   gregorian_date_calculator dut (.*);

   always #10 clock = ~clock;

   // Randomise the receiver's readiness once per cycle, on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Sample both channels on the rising edge; each transfer goes to the scoreboard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready)
            calendar_sb.note('{req_opcode, req_year_a, req_month_a, req_day_a,
                               req_year_b, req_month_b, req_day_b,
                               req_day_offset, req_diff_unit});
         if (rsp_valid && rsp_ready)
            calendar_sb.check('{rsp_status, rsp_res_year, rsp_res_month,
                                rsp_res_day, rsp_weekday, rsp_year_day,
                                rsp_month_length, rsp_difference});
      end
   end

   // Offer one request and hold it until its transfer; called at a falling edge
   task automatic send_request(date_req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_opcode     = q.opcode;
      req_year_a     = q.year_a;
      req_month_a    = q.month_a;
      req_day_a      = q.day_a;
      req_year_b     = q.year_b;
      req_month_b    = q.month_b;
      req_day_b      = q.day_b;
      req_day_offset = q.day_offset;
      req_diff_unit  = q.diff_unit;
      req_valid      = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic pick_date(output logic [YEAR_W-1:0] y, output logic [MONTH_W-1:0] m,
                            output logic [DAY_W-1:0] d);
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) y = $urandom_range(1, 3);
      else if (sel == 1) y = $urandom_range(9997, 9999);
      else if (sel == 2) y = 100 * $urandom_range(1, 99);
      else y = $urandom_range(1, 9999);
      m = $urandom_range(1, 12);
      d = ($urandom_range(3) == 0) ? days_in_month(y, m)
                                   : $urandom_range(1, days_in_month(y, m));
   endtask

   task automatic random_request(output date_req_type q);
      int sel;
      q.opcode    = ($urandom_range(9) == 0) ? OP_SPARE : 2'($urandom_range(2));
      q.diff_unit = $urandom;
      pick_date(q.year_a, q.month_a, q.day_a);
      if ($urandom_range(9) == 0) begin
         // raw fields: mostly invalid, cover every bit
         q.year_a = $urandom; q.month_a = $urandom; q.day_a = $urandom;
      end
      pick_date(q.year_b, q.month_b, q.day_b);
      sel = $urandom_range(9);
      if (sel < 3) begin
         // keep B close to A, sometimes equal
         q.year_b = q.year_a; q.month_b = q.month_a;
         if (sel == 0) q.day_b = q.day_a;
         else if (valid_date(q.year_a, q.month_a, q.day_a))
            q.day_b = $urandom_range(1, days_in_month(q.year_a, q.month_a));
      end else if (sel == 3) begin
         q.year_b = $urandom; q.month_b = $urandom; q.day_b = $urandom;
      end
      sel = $urandom_range(2);
      if (sel == 0) q.day_offset = $urandom_range(800) - 400;
      else if (sel == 1) q.day_offset = $urandom_range(2000000) - 1000000;
      else q.day_offset = $urandom;
   endtask

   date_req_type directed[$] = '{
      '{OP_DESCRIBE, 14'd1,    4'd1,  5'd1,  14'd1, 4'd1, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_DESCRIBE, 14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_ADD,      14'd1,    4'd1,  5'd1,  14'd0, 4'd0, 5'd0, -23'sd1, UNIT_DAYS},
      '{OP_ADD,      14'd9999, 4'd12, 5'd31, 14'd0, 4'd0, 5'd0, 23'sd1, UNIT_DAYS},
      '{OP_ADD,      14'd1,    4'd1,  5'd1,  14'd1, 4'd1, 5'd1, 23'sd3652058, UNIT_DAYS},
      '{OP_ADD,      14'd1,    4'd1,  5'd1,  14'd1, 4'd1, 5'd1, 23'sd4194303, UNIT_DAYS},
      '{OP_ADD,      14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1, -23'sd4194304, UNIT_DAYS},
      '{OP_ADD,      14'd2000, 4'd2,  5'd28, 14'd1, 4'd1, 5'd1, 23'sd1, UNIT_DAYS},
      '{OP_DESCRIBE, 14'd1900, 4'd2,  5'd29, 14'd1, 4'd1, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_DESCRIBE, 14'd2000, 4'd2,  5'd29, 14'd1, 4'd1, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_DESCRIBE, 14'd0,    4'd1,  5'd1,  14'd1, 4'd1, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_DESCRIBE, 14'd16383, 4'd1, 5'd1,  14'd1, 4'd1, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_DESCRIBE, 14'd2024, 4'd0,  5'd1,  14'd1, 4'd1, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_DESCRIBE, 14'd2024, 4'd15, 5'd1,  14'd1, 4'd1, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_DESCRIBE, 14'd2024, 4'd4,  5'd31, 14'd1, 4'd1, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_ADD,      14'd2024, 4'd4,  5'd0,  14'd1, 4'd1, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_DIFF,     14'd1,    4'd1,  5'd1,  14'd9999, 4'd12, 5'd31, 23'sd0, UNIT_DAYS},
      '{OP_DIFF,     14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_DIFF,     14'd2023, 4'd1,  5'd31, 14'd2023, 4'd3, 5'd31, 23'sd0, UNIT_MONTHS},
      '{OP_DIFF,     14'd2023, 4'd1,  5'd15, 14'd2024, 4'd3, 5'd20, 23'sd0, UNIT_MONTHS},
      '{OP_DIFF,     14'd2024, 4'd5,  5'd15, 14'd2020, 4'd3, 5'd2, 23'sd0, UNIT_YEARS},
      '{OP_DIFF,     14'd2024, 4'd5,  5'd15, 14'd2020, 4'd3, 5'd2, 23'sd0, UNIT_ZERO},
      '{OP_DIFF,     14'd2024, 4'd5,  5'd15, 14'd2024, 4'd5, 5'd15, 23'sd0, UNIT_MONTHS},
      '{OP_DIFF,     14'd2024, 4'd5,  5'd15, 14'd2024, 4'd13, 5'd1, 23'sd0, UNIT_DAYS},
      '{OP_SPARE,    14'd1582, 4'd10, 5'd15, 14'd0, 4'd0, 5'd0, 23'sd5, UNIT_DAYS}
   };

   initial begin
      date_req_type q;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) send_request(directed[i]);
      // three idling phases: receiver-heavy, sender-heavy, then none
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 47 : 0;
         recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 31 : 0;
         repeat (584) begin
            random_request(q);
            send_request(q);
         end
      end
      req_valid = 1'b0;
      recv_idle_pct = 0;
      while (calendar_sb.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (calendar_sb.mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
